FILE: sv/rld_pkg.sv
// Shared types, codes and helper functions for the run list decoder.
package rld_pkg;

    localparam int unsigned DataW = 64;

    // Result status codes
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] SIGN_BIT    = 8'h80;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       start_list;
        logic       buffer_end;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] start_cluster;
        logic [DataW-1:0] run_length;
        logic [1:0]       status;
        logic             any_runs;
        logic             list_done;
    } t_result;

    // OR one little-endian byte into an accumulator; bytes past the eighth drop out.
    function automatic logic [DataW-1:0] gather_byte(
        input logic [DataW-1:0] acc,
        input logic [7:0]       b,
        input logic [3:0]       pos
    );
        logic [DataW-1:0] shifted;
        shifted = {{(DataW-8){1'b0}}, b} << {pos[2:0], 3'b000};
        return pos[3] ? acc : (acc | shifted);
    endfunction

    // Ones above the top offset byte, for a byte count of 1 to 7.
    function automatic logic [DataW-1:0] ext_mask(input logic [3:0] cnt);
        return {DataW{1'b1}} << {cnt[2:0], 3'b000};
    endfunction

endpackage

FILE: sv/rld_in_reg.sv
// Input register stage: holds one accepted byte until the decode stage takes it.
module rld_in_reg
    import rld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_fire,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    assign w_load  = !r_valid || i_fire;
    assign o_stall = !w_load;
    assign n_valid = w_load ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/rld_decode.sv
// Decode stage: run list state, accumulators and start cluster adder.
module rld_decode
    import rld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [3:0] {
        PH_DONE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_OFFSET = 4'b1000
    } t_phase;

    t_phase           r_phase, n_phase, w_phase;
    logic [3:0]       r_len_left, n_len_left;
    logic [3:0]       r_off_left, n_off_left;
    logic [3:0]       r_off_cnt, n_off_cnt;
    logic [3:0]       r_pos, n_pos;
    logic [DataW-1:0] r_len_acc, n_len_acc;
    logic [DataW-1:0] r_off_acc, n_off_acc;
    logic [DataW-1:0] r_prev, n_prev, w_prev;
    logic             r_runs, n_runs;

    logic [DataW-1:0] w_len_gath, w_off_gath, w_offs, w_lcn_off;
    logic [3:0]       w_len_dec, w_off_dec;
    logic             w_sign_ext;
    logic             w_emit;
    t_result          w_res;
    logic [7:0]       w_b;
    logic             w_last;

    assign w_b        = i_item.run_byte;
    assign w_last     = i_item.buffer_end;
    assign w_len_gath = gather_byte(r_len_acc, w_b, r_pos);
    assign w_off_gath = gather_byte(r_off_acc, w_b, r_pos);
    assign w_len_dec  = r_len_left - 4'd1;
    assign w_off_dec  = r_off_left - 4'd1;
    // top offset byte carries the sign unless eight or more bytes were given
    assign w_sign_ext = !r_off_cnt[3] && ((w_b & SIGN_BIT) != 8'd0);
    assign w_offs     = w_off_gath | (w_sign_ext ? ext_mask(r_off_cnt) : '0);
    assign w_lcn_off  = r_prev + w_offs;

    always_comb begin
        w_phase    = i_item.start_list ? PH_HEADER : r_phase;
        w_prev     = i_item.start_list ? '0 : r_prev;
        n_phase    = w_phase;
        n_prev     = w_prev;
        n_runs     = i_item.start_list ? 1'b0 : r_runs;
        n_len_left = r_len_left;
        n_off_left = r_off_left;
        n_off_cnt  = r_off_cnt;
        n_pos      = r_pos;
        n_len_acc  = r_len_acc;
        n_off_acc  = r_off_acc;
        w_emit     = 1'b0;
        w_res      = '0;

        unique case (w_phase)
            PH_HEADER: begin
                w_emit          = 1'b1;
                w_res.list_done = 1'b1;
                n_phase         = PH_DONE;
                if (w_b == 8'd0) begin
                    w_res.status = ST_END;
                end else if (w_b[7:4] == 4'd0) begin
                    w_res.status = ST_ZERO_LEN;
                end else if (w_last) begin
                    w_res.status = ST_TRUNC;
                end else begin
                    w_emit          = 1'b0;
                    w_res.list_done = 1'b0;
                    n_phase         = PH_LENGTH;
                    n_len_left      = w_b[7:4];
                    n_off_left      = w_b[3:0] & NIBBLE_MASK[3:0];
                    n_off_cnt       = w_b[3:0];
                    n_pos           = 4'd0;
                    n_len_acc       = '0;
                    n_off_acc       = '0;
                end
            end
            PH_LENGTH: begin
                n_len_acc  = w_len_gath;
                n_len_left = w_len_dec;
                n_pos      = r_pos + 4'd1;
                if (w_len_dec == 4'd0 && r_off_left == 4'd0) begin
                    // run with no offset bytes starts at the previous cluster
                    w_emit              = 1'b1;
                    w_res.start_cluster = r_prev;
                    w_res.run_length    = w_len_gath;
                    w_res.status        = ST_RUN;
                    w_res.list_done     = w_last;
                    n_runs              = 1'b1;
                    n_phase             = w_last ? PH_DONE : PH_HEADER;
                end else begin
                    if (w_len_dec == 4'd0) begin
                        n_pos   = 4'd0;
                        n_phase = PH_OFFSET;
                    end
                    if (w_last) begin
                        w_emit          = 1'b1;
                        w_res.status    = ST_TRUNC;
                        w_res.list_done = 1'b1;
                        n_phase         = PH_DONE;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc  = w_off_gath;
                n_off_left = w_off_dec;
                n_pos      = r_pos + 4'd1;
                if (w_off_dec == 4'd0) begin
                    w_emit              = 1'b1;
                    w_res.start_cluster = w_lcn_off;
                    w_res.run_length    = r_len_acc;
                    w_res.status        = ST_RUN;
                    w_res.list_done     = w_last;
                    n_prev              = w_lcn_off;
                    n_runs              = 1'b1;
                    n_phase             = w_last ? PH_DONE : PH_HEADER;
                end else if (w_last) begin
                    w_emit          = 1'b1;
                    w_res.status    = ST_TRUNC;
                    w_res.list_done = 1'b1;
                    n_phase         = PH_DONE;
                end
            end
            PH_DONE: begin
                // stray bytes between lists are dropped
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        w_res.any_runs = n_runs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DONE;
            r_len_left <= '0;
            r_off_left <= '0;
            r_off_cnt  <= '0;
            r_pos      <= '0;
            r_len_acc  <= '0;
            r_off_acc  <= '0;
            r_prev     <= '0;
            r_runs     <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_off_cnt  <= n_off_cnt;
            r_pos      <= n_pos;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_prev     <= n_prev;
            r_runs     <= n_runs;
        end
    end

    assign o_res_valid = i_fire && w_emit;
    assign o_res       = w_res;

endmodule

FILE: sv/rld_out_reg.sv
// Output register: holds one result until the receiver takes it.
module rld_out_reg
    import rld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // free when empty or when the held result transfers this cycle
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = o_free ? i_res_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: sv/run_list_decoder_core.sv
// Top level of the run list decoder.
//
// Bytes of a run list enter on the input channel (i_in_valid / o_in_stall), one
// per transfer, with i_start_list on the first header byte and i_buffer_end on
// the last byte of the record. Each completed run, and each end of list, comes
// out as one result transfer on the output channel (o_out_valid / i_out_stall):
// start cluster, run length, status, any_runs and list_done. Other length and
// offset bytes give no result.
// A byte is held in the input register and is decoded into the output register
// once that register is free, so its result is registered there before it can
// transfer. Throughput is one byte per cycle while the receiver does not stall;
// the decode stage's 64-bit start cluster adder sets the path length.
// When the receiver stalls, the output register holds its result, the input
// register holds one more byte, and then o_in_stall rises. Nothing is dropped.
// Reset (synchronous, active low) empties both registers and leaves the decoder
// waiting for a byte marked i_start_list; other bytes are ignored until then.
module run_list_decoder_core
    import rld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_run_byte,
    input  logic             i_start_list,
    input  logic             i_buffer_end,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [DataW-1:0] o_start_cluster,
    output logic [DataW-1:0] o_run_length,
    output logic [1:0]       o_status,
    output logic             o_any_runs,
    output logic             o_list_done
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_fire;
    logic    w_out_free;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    assign w_in_item.run_byte   = i_run_byte;
    assign w_in_item.start_list = i_start_list;
    assign w_in_item.buffer_end = i_buffer_end;

    assign w_fire = w_item_valid && w_out_free;

    rld_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_fire  (w_fire),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    rld_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    rld_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (w_out_res)
    );

    assign o_start_cluster = w_out_res.start_cluster;
    assign o_run_length    = w_out_res.run_length;
    assign o_status        = w_out_res.status;
    assign o_any_runs      = w_out_res.any_runs;
    assign o_list_done     = w_out_res.list_done;

endmodule

FILE: test/run_list_decoder_checker.sv
// Watches both channels of the run list decoder, predicts each result and compares it.
module run_list_decoder_checker
    import rld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [7:0]       i_run_byte,
    input  logic             i_start_list,
    input  logic             i_buffer_end,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [DataW-1:0] i_start_cluster,
    input  logic [DataW-1:0] i_run_length,
    input  logic [1:0]       i_status,
    input  logic             i_any_runs,
    input  logic             i_list_done,
    output int               o_fail_count,
    output int               o_pending
);

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_LENGTH, PH_OFFSET} t_phase;

    t_phase           phase;
    logic [3:0]       len_left;
    logic [3:0]       off_left;
    logic [3:0]       off_count;
    logic [3:0]       byte_pos;
    logic [DataW-1:0] len_acc;
    logic [DataW-1:0] off_acc;
    logic [DataW-1:0] prev_lcn;
    logic             runs_seen;
    t_result          runs_due[$];

    // Little-endian byte merge; bytes past the eighth are dropped.
    function automatic logic [DataW-1:0] merge_byte(input logic [DataW-1:0] acc,
                                                    input logic [7:0] b,
                                                    input logic [3:0] pos);
        logic [DataW-1:0] wide;
        wide = {{(DataW-8){1'b0}}, b};
        if (pos < 4'd8) begin
            return acc | (wide << (8 * pos));
        end
        return acc;
    endfunction

    task automatic queue_result(input logic [DataW-1:0] lcn, input logic [DataW-1:0] len,
                                input logic [1:0] st, input logic done);
        t_result r;
        r.start_cluster = lcn;
        r.run_length    = len;
        r.status        = st;
        r.any_runs      = runs_seen;
        r.list_done     = done;
        runs_due = {runs_due, r};
        if (done) begin
            phase = PH_IDLE;
        end
    endtask

    task automatic close_run(input logic last);
        logic [DataW-1:0] offs;
        offs = off_acc;
        if (off_count > 4'd0 && off_count < 4'd8 && offs[8 * off_count - 1]) begin
            offs = offs | ({DataW{1'b1}} << (8 * off_count));
        end
        prev_lcn  = prev_lcn + offs;
        runs_seen = 1'b1;
        phase     = PH_HEADER;
        queue_result(prev_lcn, len_acc, ST_RUN, last);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start, input logic last);
        if (start) begin
            prev_lcn  = '0;
            runs_seen = 1'b0;
            phase     = PH_HEADER;
        end
        case (phase)
            PH_HEADER: begin
                if (b == 8'h00) begin
                    queue_result('0, '0, ST_END, 1'b1);
                end else if (b[7:4] == 4'h0) begin
                    queue_result('0, '0, ST_ZERO_LEN, 1'b1);
                end else if (last) begin
                    queue_result('0, '0, ST_TRUNC, 1'b1);
                end else begin
                    len_left  = b[7:4];
                    off_left  = b[3:0] & NIBBLE_MASK[3:0];
                    off_count = b[3:0] & NIBBLE_MASK[3:0];
                    byte_pos  = 4'd0;
                    len_acc   = '0;
                    off_acc   = '0;
                    phase     = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                len_acc  = merge_byte(len_acc, b, byte_pos);
                byte_pos = byte_pos + 4'd1;
                len_left = len_left - 4'd1;
                if (len_left == 4'd0 && off_left == 4'd0) begin
                    close_run(last);
                end else begin
                    if (len_left == 4'd0) begin
                        byte_pos = 4'd0;
                        phase    = PH_OFFSET;
                    end
                    if (last) begin
                        queue_result('0, '0, ST_TRUNC, 1'b1);
                    end
                end
            end
            PH_OFFSET: begin
                off_acc  = merge_byte(off_acc, b, byte_pos);
                byte_pos = byte_pos + 4'd1;
                off_left = off_left - 4'd1;
                if (off_left == 4'd0) begin
                    // sign taken from the last byte, and only when fewer than eight offset bytes were given
                    if (off_count >= 4'd8) begin
                        off_count = 4'd8;
                    end else if ((b & SIGN_BIT) == 8'h00) begin
                        off_count = 4'd0;
                    end
                    close_run(last);
                end else if (last) begin
                    queue_result('0, '0, ST_TRUNC, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase     = PH_IDLE;
            len_left  = 4'd0;
            off_left  = 4'd0;
            off_count = 4'd0;
            byte_pos  = 4'd0;
            len_acc   = '0;
            off_acc   = '0;
            prev_lcn  = '0;
            runs_seen = 1'b0;
            runs_due.delete();
        end else begin
            // output first: a result leaving now never belongs to the byte entering now
            if (i_out_valid && !i_out_stall) begin
                if (runs_due.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result: lcn=%h len=%h st=%0d any=%b done=%b",
                                 i_start_cluster, i_run_length, i_status, i_any_runs,
                                 i_list_done);
                    end
                end else begin
                    want = runs_due.pop_front();
                    if (want.start_cluster !== i_start_cluster ||
                        want.run_length !== i_run_length ||
                        want.status !== i_status ||
                        want.any_runs !== i_any_runs ||
                        want.list_done !== i_list_done) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("result mismatch: want lcn=%h len=%h st=%0d any=%b done=%b",
                                     want.start_cluster, want.run_length, want.status,
                                     want.any_runs, want.list_done);
                            $display("                 got  lcn=%h len=%h st=%0d any=%b done=%b",
                                     i_start_cluster, i_run_length, i_status, i_any_runs,
                                     i_list_done);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_run_byte, i_start_list, i_buffer_end);
            end
        end
        o_pending = runs_due.size();
    end

endmodule

FILE: test/tb_run_list_decoder_core.sv
// Stimulus and verdict for the run list decoder; prediction lives in the checker.
module tb_run_list_decoder_core
    import rld_pkg::*;
();

    localparam int RandomItems = 1400;
    localparam int HoldOff     = 400;
    localparam int StallLimit  = 3000;
    localparam int DrainCycles = 8;

    typedef enum {LE_ZERO_HDR, LE_ZERO_LEN, LE_HDR_CUT, LE_LAST_RUN, LE_CUT, LE_ABANDON} t_list_end;
    typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} t_rx_mode;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_run_byte;
    logic             i_start_list;
    logic             i_buffer_end;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [DataW-1:0] o_start_cluster;
    logic [DataW-1:0] o_run_length;
    logic [1:0]       o_status;
    logic             o_any_runs;
    logic             o_list_done;

    int       fail_count;
    int       pending;
    int       idle_cycles = 0;
    int       hold_cycles = 0;
    int       burst_left  = 1;
    int       items_sent  = 0;
    logic     sender_live = 1'b0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    run_list_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_run_byte      (i_run_byte),
        .i_start_list    (i_start_list),
        .i_buffer_end    (i_buffer_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_start_cluster (o_start_cluster),
        .o_run_length    (o_run_length),
        .o_status        (o_status),
        .o_any_runs      (o_any_runs),
        .o_list_done     (o_list_done)
    );

    run_list_decoder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_run_byte      (i_run_byte),
        .i_start_list    (i_start_list),
        .i_buffer_end    (i_buffer_end),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_start_cluster (o_start_cluster),
        .i_run_length    (o_run_length),
        .i_status        (o_status),
        .i_any_runs      (o_any_runs),
        .i_list_done     (o_list_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == StallLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise stretches of random stall density
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(5, 60);
                end
                rx_left = rx_left - 1;
                case (rx_mode)
                    RX_OPEN:  i_out_stall <= 1'b0;
                    RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HALF:  i_out_stall <= ($urandom_range(0, 1) == 1);
                    default:  i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // one byte transfer; called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        i_in_valid   <= 1'b1;
        i_run_byte   <= b;
        i_start_list <= first;
        i_buffer_end <= last;
        sender_live  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                sender_live = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        if (sender_live) begin
            i_in_valid <= 1'b0;
            sender_live = 1'b0;
        end
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // byte count for a length or offset field; mostly short, sometimes past eight
    function automatic logic [3:0] field_bytes(input int lowest);
        if ($urandom_range(0, 9) == 0) begin
            return 4'($urandom_range(lowest, 15));
        end
        return 4'($urandom_range(lowest, 3));
    endfunction

    task automatic send_list(input int n_runs, input t_list_end ending);
        logic [7:0] bytes[$];
        logic [3:0] len_n;
        logic [3:0] off_n;
        int         runs;
        int         last_at;
        int         n_send;
        runs    = (n_runs == 0 && ending >= LE_LAST_RUN) ? 1 : n_runs;
        last_at = -1;
        for (int r = 0; r < runs; r++) begin
            len_n = field_bytes(1);
            off_n = field_bytes(0);
            bytes = {bytes, {len_n, off_n}};
            repeat (int'(len_n) + int'(off_n)) bytes = {bytes, 8'($urandom_range(0, 255))};
        end
        case (ending)
            LE_ZERO_HDR: begin
                bytes = {bytes, 8'h00};
                if ($urandom_range(0, 1)) last_at = bytes.size() - 1;
            end
            LE_ZERO_LEN: begin
                off_n = 4'($urandom_range(1, 15));
                bytes = {bytes, {4'h0, off_n}};
                if ($urandom_range(0, 1)) last_at = bytes.size() - 1;
            end
            LE_HDR_CUT: begin
                len_n = 4'($urandom_range(1, 15));
                off_n = 4'($urandom_range(0, 15));
                bytes = {bytes, {len_n, off_n}};
                last_at = bytes.size() - 1;
            end
            LE_LAST_RUN: last_at = bytes.size() - 1;
            LE_CUT:      last_at = $urandom_range(0, bytes.size() - 1);
            default: begin
            end
        endcase
        // an abandoned list stops anywhere and is cut short by the next start
        n_send = (ending == LE_ABANDON) ? $urandom_range(1, bytes.size()) : bytes.size();
        for (int i = 0; i < n_send; i++) begin
            send_byte(bytes[i], i == 0, i == last_at);
        end
        items_sent = items_sent + n_send;
    endtask

    initial begin
        int        list_no;
        t_list_end ending;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_run_byte   = 8'h00;
        i_start_list = 1'b0;
        i_buffer_end = 1'b0;
        list_no      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'hFF, 1'b0, 1'b0);   // idle byte, ignored
        send_byte(8'h11, 1'b1, 1'b0);   // len 255, offset -128 wraps below zero
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h10, 1'b0, 1'b0);   // no offset bytes, zero length
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);   // zero length count together with buffer end
        send_byte(8'h00, 1'b1, 1'b1);   // end marker on the start byte
        send_byte(8'h31, 1'b1, 1'b1);   // buffer ends on a run header
        send_byte(8'h21, 1'b1, 1'b0);   // buffer ends between length and offset
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'h07, 1'b0, 1'b1);
        send_byte(8'h11, 1'b1, 1'b0);   // buffer ends on the last byte of a run
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'h12, 1'b1, 1'b0);   // restart in the middle of an offset
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        drain_results();

        while (items_sent < RandomItems) begin
            list_no = list_no + 1;
            if (list_no == 15) begin
                hold_cycles = HoldOff;   // receiver holds off while lists keep coming
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ending = LE_ZERO_HDR;
                4:          ending = LE_ZERO_LEN;
                5:          ending = LE_HDR_CUT;
                6:          ending = LE_LAST_RUN;
                7, 8:       ending = LE_CUT;
                default:    ending = LE_ABANDON;
            endcase
            send_list($urandom_range(0, 6), ending);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                end
            end
            if (list_no == 30 || $urandom_range(0, 9) == 0) begin
                drain_results();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
